/* sv/fpr_pkg.sv */
// shared types, codes and constants of the framed packet receiver
package fpr_pkg;

  localparam int unsigned MaxPayload = 128;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned EventW  = 2;
  localparam int unsigned FaultW  = 3;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  localparam logic [CfgAddrW-1:0] RegStartWord = 2'd0;
  localparam logic [CfgAddrW-1:0] RegEndWord   = 2'd1;
  localparam logic [CfgAddrW-1:0] RegDirCode   = 2'd2;
  localparam logic [CfgAddrW-1:0] RegCmdCode   = 2'd3;

  localparam logic [EventW-1:0] EvPayload = 2'd0;
  localparam logic [EventW-1:0] EvGood    = 2'd1;
  localparam logic [EventW-1:0] EvFault   = 2'd2;

  localparam logic [FaultW-1:0] FaultNone    = 3'd0;
  localparam logic [FaultW-1:0] FaultStart   = 3'd1;
  localparam logic [FaultW-1:0] FaultDir     = 3'd2;
  localparam logic [FaultW-1:0] FaultCmd     = 3'd3;
  localparam logic [FaultW-1:0] FaultTooLong = 3'd4;
  localparam logic [FaultW-1:0] FaultCsum    = 3'd5;
  localparam logic [FaultW-1:0] FaultEnd     = 3'd6;

  localparam logic [ByteW-1:0] TallyMax = 8'hFF;

  typedef struct packed {
    logic              valid;
    logic [EventW-1:0] ev;
    logic [ByteW-1:0]  payload_byte;
    logic [IndexW-1:0] payload_index;
    logic [ByteW-1:0]  frame_command;
    logic [ByteW-1:0]  frame_length;
    logic [FaultW-1:0] fault_code;
    logic [ByteW-1:0]  fault_count;
  } fpr_result_t;

endpackage

/* sv/framed_packet_receiver_top.sv */
// top level of the framed packet receiver
// Takes one received byte (or a release beat) per cycle and checks it against the frame
// layout start word, direction, command, big-endian length, payload, inverted additive
// checksum and end word. Each payload byte, a good frame and each fault give one output
// beat. Parsing is a single state update per beat, so a new beat is accepted every cycle;
// a two-entry output buffer keeps input flowing while the output is stalled until one more
// result is parked in the skid register, after which input waits until the stalled output
// beat is taken. A result goes straight into the output register when that register is free
// or drains in the cycle of the input beat that causes it, and into the skid register otherwise.
module framed_packet_receiver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fpr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [fpr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // rx_byte
  input  logic [fpr_pkg::InDataW-1:0]   s_axis_tdata_i,
  // kind
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // payload_byte, payload_index, frame_command, frame_length, fault_code, fault_count, zeros
  output logic [fpr_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // event_res
  output logic [fpr_pkg::EventW-1:0]    m_axis_tuser_o
);
  import fpr_pkg::*;

  fpr_result_t res, out_res;
  logic        beat;

  assign beat = s_axis_tvalid_i && s_axis_tready_o;

  fpr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .beat_i      (beat),
    .kind_i      (s_axis_tuser_i),
    .rx_i        (s_axis_tdata_i),
    .res_o       (res)
  );

  fpr_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .ready_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tuser_o = out_res.ev;
  assign m_axis_tdata_o = {6'd0, out_res.fault_count, out_res.fault_code,
                           out_res.frame_length, out_res.frame_command,
                           out_res.payload_index, out_res.payload_byte};

endmodule

/* sv/fpr_parser.sv */
// frame parser: config registers, parse state and a result for each payload byte, good frame and fault
module fpr_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fpr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [fpr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          beat_i,
  input  logic                          kind_i,
  input  logic [fpr_pkg::ByteW-1:0]     rx_i,
  output fpr_pkg::fpr_result_t          res_o
);
  import fpr_pkg::*;

  localparam logic [2:0] PhStart = 3'd0;
  localparam logic [2:0] PhDir   = 3'd1;
  localparam logic [2:0] PhCmd   = 3'd2;
  localparam logic [2:0] PhLen   = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhCsum  = 3'd5;
  localparam logic [2:0] PhEnd   = 3'd6;

  logic [15:0]       start_word_q, end_word_q;
  logic [ByteW-1:0]  dir_code_q, cmd_code_q;

  logic [2:0]        phase_q, phase_d;
  logic              half_q, half_d;
  logic [ByteW-1:0]  len_hi_q, len_hi_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [IndexW-1:0] taken_q, taken_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [ByteW-1:0]  tally_q, tally_d;
  logic              hold_q, hold_d;
  logic              discard_q, discard_d;

  logic              fault_hit;
  logic [FaultW-1:0] fault_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_word_q <= '0;
      end_word_q   <= '0;
      dir_code_q   <= '0;
      cmd_code_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegStartWord: start_word_q <= cfg_wdata_i;
        RegEndWord:   end_word_q   <= cfg_wdata_i;
        RegDirCode:   dir_code_q   <= cfg_wdata_i[ByteW-1:0];
        RegCmdCode:   cmd_code_q   <= cfg_wdata_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    half_d    = half_q;
    len_hi_d  = len_hi_q;
    len_d     = len_q;
    taken_d   = taken_q;
    sum_d     = sum_q;
    cmd_d     = cmd_q;
    tally_d   = tally_q;
    hold_d    = hold_q;
    discard_d = discard_q;
    fault_hit = 1'b0;
    fault_sel = FaultNone;
    res_o     = '0;

    if (beat_i) begin
      if (kind_i) begin
        hold_d = 1'b0;
      end else if (hold_q) begin
        hold_d = 1'b1;
      end else if (discard_q) begin
        discard_d = 1'b0;
      end else begin
        case (phase_q)
          PhStart: begin
            if (!half_q) begin
              if (rx_i != start_word_q[15:8]) begin
                fault_hit = 1'b1;
                fault_sel = FaultStart;
              end else begin
                half_d = 1'b1;
              end
            end else begin
              half_d = 1'b0;
              if (rx_i != start_word_q[7:0]) begin
                fault_hit = 1'b1;
                fault_sel = FaultStart;
              end else begin
                phase_d = PhDir;
              end
            end
          end
          PhDir: begin
            if (rx_i != dir_code_q) begin
              fault_hit = 1'b1;
              fault_sel = FaultDir;
            end else begin
              phase_d = PhCmd;
            end
          end
          PhCmd: begin
            if (rx_i != cmd_code_q) begin
              fault_hit = 1'b1;
              fault_sel = FaultCmd;
            end else begin
              cmd_d   = rx_i;
              sum_d   = rx_i;
              half_d  = 1'b0;
              phase_d = PhLen;
            end
          end
          PhLen: begin
            if (!half_q) begin
              len_hi_d = rx_i;
              half_d   = 1'b1;
            end else begin
              half_d = 1'b0;
              len_d  = rx_i;
              if ({len_hi_q, rx_i} > 16'(MaxPayload)) begin
                fault_hit = 1'b1;
                fault_sel = FaultTooLong;
              end else begin
                taken_d = '0;
                phase_d = (rx_i == '0) ? PhCsum : PhData;
              end
            end
          end
          PhData: begin
            sum_d = sum_q + rx_i;
            if (({1'b0, taken_q} + 8'd1) >= len_q) begin
              taken_d = '0;
              phase_d = PhCsum;
            end else begin
              taken_d = taken_q + 1'b1;
            end
            res_o.valid         = 1'b1;
            res_o.ev            = EvPayload;
            res_o.payload_byte  = rx_i;
            res_o.payload_index = taken_q;
            res_o.frame_command = cmd_q;
            res_o.frame_length  = len_q;
            res_o.fault_count   = tally_q;
          end
          PhCsum: begin
            if (rx_i != ~sum_q) begin
              fault_hit = 1'b1;
              fault_sel = FaultCsum;
            end else begin
              half_d  = 1'b0;
              phase_d = PhEnd;
            end
          end
          PhEnd: begin
            if (!half_q) begin
              if (rx_i != end_word_q[15:8]) begin
                fault_hit = 1'b1;
                fault_sel = FaultEnd;
              end else begin
                half_d = 1'b1;
              end
            end else begin
              half_d = 1'b0;
              if (rx_i != end_word_q[7:0]) begin
                fault_hit = 1'b1;
                fault_sel = FaultEnd;
              end else begin
                phase_d             = PhStart;
                hold_d              = 1'b1;
                res_o.valid         = 1'b1;
                res_o.ev            = EvGood;
                res_o.frame_command = cmd_q;
                res_o.frame_length  = len_q;
                res_o.fault_count   = tally_q;
              end
            end
          end
          default: begin
            phase_d = PhStart;
            half_d  = 1'b0;
          end
        endcase

        if (fault_hit) begin
          if (tally_q != TallyMax) begin
            tally_d = tally_q + 1'b1;
          end
          phase_d           = PhStart;
          half_d            = 1'b0;
          discard_d         = 1'b1;
          res_o             = '0;
          res_o.valid       = 1'b1;
          res_o.ev          = EvFault;
          res_o.fault_code  = fault_sel;
          res_o.fault_count = tally_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhStart;
      half_q    <= 1'b0;
      len_hi_q  <= '0;
      len_q     <= '0;
      taken_q   <= '0;
      sum_q     <= '0;
      cmd_q     <= '0;
      tally_q   <= '0;
      hold_q    <= 1'b0;
      discard_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      half_q    <= half_d;
      len_hi_q  <= len_hi_d;
      len_q     <= len_d;
      taken_q   <= taken_d;
      sum_q     <= sum_d;
      cmd_q     <= cmd_d;
      tally_q   <= tally_d;
      hold_q    <= hold_d;
      discard_q <= discard_d;
    end
  end

endmodule

/* sv/fpr_outbuf.sv */
// two-entry output buffer: result register plus skid register
module fpr_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fpr_pkg::fpr_result_t res_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output fpr_pkg::fpr_result_t res_o
);
  import fpr_pkg::*;

  fpr_result_t out_q, skid_q;
  logic        out_v_q, skid_v_q;
  logic        out_fire;

  assign out_fire = out_v_q && ready_i;
  assign ready_o  = !skid_v_q;
  assign valid_o  = out_v_q;
  assign res_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_fire) begin
        skid_v_q <= 1'b0;
      end
    end else if (res_i.valid) begin
      if (!out_v_q || out_fire) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_i.valid) begin
      if (!out_v_q || out_fire) begin
        out_q <= res_i;
      end else begin
        skid_q <= res_i;
      end
    end
  end

endmodule

/* sv/fpr_checker.sv */
// port-level checks of the framed packet receiver and their bind
module fpr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [fpr_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [fpr_pkg::EventW-1:0]    m_axis_tuser_o
);
  import fpr_pkg::*;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output beat changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  a_payload_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == EvPayload |->
      {1'b0, m_axis_tdata_o[14:8]} < m_axis_tdata_o[30:23] &&
      m_axis_tdata_o[33:31] == FaultNone)
    else $error("payload beat index or fault code wrong");

  a_fault_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == EvFault |->
      m_axis_tdata_o[33:31] != FaultNone && m_axis_tdata_o[41:34] != '0 &&
      m_axis_tdata_o[30:0] == '0)
    else $error("fault beat fields wrong");

endmodule

bind framed_packet_receiver_top fpr_checker u_fpr_checker (.*);

/* tb/framed_packet_receiver_top_tb.sv */
// self-checking testbench of the framed packet receiver: directed table, random frames, scoreboard
module framed_packet_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpr_pkg::*;

  localparam logic KindByte    = 1'b0;
  localparam logic KindRelease = 1'b1;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldOff      = 400;
  localparam int unsigned PhaseBeats   = 200;
  localparam int unsigned NoiseBeats   = 600;

  typedef enum logic [2:0] {
    WaitStart, WaitDir, WaitCmd, WaitLen, TakeData, WaitCsum, WaitEnd
  } parse_phase_e;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] rx;
  } rx_beat_t;

  typedef struct {
    logic             kind;
    logic [ByteW-1:0] rx;
    bit               fixed;
    fpr_result_t      res;
  } table_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic [InDataW-1:0]  in_data = '0;
  logic                in_kind = 1'b0;
  logic                out_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  // payload_byte, payload_index, frame_command, frame_length, fault_code, fault_count, zeros
  logic [OutDataW-1:0] m_axis_tdata_o;
  // event_res
  logic [EventW-1:0]   m_axis_tuser_o;

  framed_packet_receiver_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_kind),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // mirrored receiver state
  logic [15:0]      start_word_q = '0;
  logic [15:0]      end_word_q = '0;
  logic [ByteW-1:0] dir_code_q = '0;
  logic [ByteW-1:0] cmd_code_q = '0;
  parse_phase_e     phase = WaitStart;
  logic             second_half = 1'b0;
  logic [15:0]      len_q = '0;
  logic [IndexW-1:0] taken = '0;
  logic [ByteW-1:0] sum_q = '0;
  logic [ByteW-1:0] held_cmd = '0;
  logic [ByteW-1:0] tally = '0;
  logic             holding = 1'b0;
  logic             drop_next = 1'b0;

  fpr_result_t expected_results[$];
  table_row_t  directed[$];
  fpr_result_t want;
  int unsigned failures = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned good_seen = 0;
  int unsigned faults_seen = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  function automatic fpr_result_t raise_fault(input logic [FaultW-1:0] code);
    fpr_result_t f;
    if (tally < TallyMax) tally++;
    phase = WaitStart;
    second_half = 1'b0;
    drop_next = 1'b1;
    f = '0;
    f.valid = 1'b1;
    f.ev = EvFault;
    f.fault_code = code;
    f.fault_count = tally;
    return f;
  endfunction

  task automatic predict_beat(input logic kind, input logic [ByteW-1:0] rx,
                              output fpr_result_t r);
    logic [IndexW-1:0] idx;
    r = '0;
    if (kind == KindRelease) begin
      holding = 1'b0;
    end else if (holding) begin
      r = '0;
    end else if (drop_next) begin
      drop_next = 1'b0;
    end else begin
      case (phase)
        WaitStart: begin
          if (!second_half) begin
            if (rx != start_word_q[15:8]) r = raise_fault(FaultStart);
            else second_half = 1'b1;
          end else begin
            second_half = 1'b0;
            if (rx != start_word_q[7:0]) r = raise_fault(FaultStart);
            else phase = WaitDir;
          end
        end
        WaitDir: begin
          if (rx != dir_code_q) r = raise_fault(FaultDir);
          else phase = WaitCmd;
        end
        WaitCmd: begin
          if (rx != cmd_code_q) begin
            r = raise_fault(FaultCmd);
          end else begin
            held_cmd = rx;
            sum_q = rx;
            second_half = 1'b0;
            phase = WaitLen;
          end
        end
        WaitLen: begin
          if (!second_half) begin
            len_q = {rx, 8'h00};
            second_half = 1'b1;
          end else begin
            second_half = 1'b0;
            len_q = {len_q[15:8], rx};
            if (len_q > MaxPayload) begin
              r = raise_fault(FaultTooLong);
            end else begin
              taken = '0;
              phase = (len_q == 0) ? WaitCsum : TakeData;
            end
          end
        end
        TakeData: begin
          idx = taken;
          sum_q = sum_q + rx;
          if (int'(idx) + 1 >= int'(len_q)) begin
            taken = '0;
            phase = WaitCsum;
          end else begin
            taken = idx + 1'b1;
          end
          r.valid = 1'b1;
          r.ev = EvPayload;
          r.payload_byte = rx;
          r.payload_index = idx;
          r.frame_command = held_cmd;
          r.frame_length = len_q[7:0];
          r.fault_code = FaultNone;
          r.fault_count = tally;
        end
        WaitCsum: begin
          if (rx != ~sum_q) begin
            r = raise_fault(FaultCsum);
          end else begin
            second_half = 1'b0;
            phase = WaitEnd;
          end
        end
        WaitEnd: begin
          if (!second_half) begin
            if (rx != end_word_q[15:8]) r = raise_fault(FaultEnd);
            else second_half = 1'b1;
          end else begin
            second_half = 1'b0;
            if (rx != end_word_q[7:0]) begin
              r = raise_fault(FaultEnd);
            end else begin
              phase = WaitStart;
              holding = 1'b1;
              r.valid = 1'b1;
              r.ev = EvGood;
              r.frame_command = held_cmd;
              r.frame_length = len_q[7:0];
              r.fault_code = FaultNone;
              r.fault_count = tally;
            end
          end
        end
        default: begin
          phase = WaitStart;
          second_half = 1'b0;
        end
      endcase
    end
  endtask

  task automatic send_beat(input logic kind, input logic [ByteW-1:0] rx,
                           output fpr_result_t res);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data <= rx;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_beat(kind, rx, res);
    beats_sent++;
  endtask

  task automatic send_and_predict(input logic kind, input logic [ByteW-1:0] rx);
    fpr_result_t res;
    send_beat(kind, rx, res);
    if (res.valid) expected_results.push_back(res);
  endtask

  task automatic add_row(input logic kind, input logic [ByteW-1:0] rx, input bit fixed,
                         input logic [EventW-1:0] ev, input logic [ByteW-1:0] cmd,
                         input logic [ByteW-1:0] len, input logic [FaultW-1:0] code,
                         input logic [ByteW-1:0] count);
    table_row_t row;
    row.kind = kind;
    row.rx = rx;
    row.fixed = fixed;
    row.res = '0;
    row.res.valid = 1'b1;
    row.res.ev = ev;
    row.res.frame_command = cmd;
    row.res.frame_length = len;
    row.res.fault_code = code;
    row.res.fault_count = count;
    directed.push_back(row);
  endtask

  task automatic wait_quiet();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] sw, input logic [15:0] ew,
                              input logic [ByteW-1:0] dc, input logic [ByteW-1:0] cc);
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    cfg_we <= 1'b1;
    cfg_addr <= RegStartWord;
    cfg_wdata <= sw;
    @(posedge clk_i);
    cfg_addr <= RegEndWord;
    cfg_wdata <= ew;
    @(posedge clk_i);
    cfg_addr <= RegDirCode;
    cfg_wdata <= {junk, dc};
    @(posedge clk_i);
    cfg_addr <= RegCmdCode;
    cfg_wdata <= {~junk, cc};
    @(posedge clk_i);
    cfg_we <= 1'b0;
    start_word_q = sw;
    end_word_q = ew;
    dir_code_q = dc;
    cmd_code_q = cc;
  endtask

  task automatic send_frame(input bit broken, input int forced_len);
    rx_beat_t    seq[$];
    int          n;
    int          pick;
    int          pos;
    logic [15:0] n16;
    logic [7:0]  sum;
    logic [7:0]  b;
    if (forced_len >= 0) begin
      n = forced_len;
    end else begin
      pick = $urandom_range(99);
      if (pick < 3) n = 128;
      else if (pick < 6) n = $urandom_range(20, 127);
      else if (pick < 14) n = 0;
      else n = $urandom_range(1, 6);
    end
    n16 = 16'(n);
    sum = cmd_code_q;
    seq.push_back({KindByte, start_word_q[15:8]});
    seq.push_back({KindByte, start_word_q[7:0]});
    seq.push_back({KindByte, dir_code_q});
    seq.push_back({KindByte, cmd_code_q});
    seq.push_back({KindByte, n16[15:8]});
    seq.push_back({KindByte, n16[7:0]});
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      sum = sum + b;
      seq.push_back({KindByte, b});
    end
    seq.push_back({KindByte, ~sum});
    seq.push_back({KindByte, end_word_q[15:8]});
    seq.push_back({KindByte, end_word_q[7:0]});
    if (broken) begin
      pos = $urandom_range(0, seq.size() - 1);
      b = 8'($urandom_range(1, 255));
      seq[pos].rx = seq[pos].rx ^ b;
    end
    // a stray byte before the release beat, dropped while a good frame is held
    if ($urandom_range(9) == 0) seq.push_back({KindByte, 8'($urandom_range(255))});
    seq.push_back({KindRelease, 8'($urandom_range(255))});
    foreach (seq[i]) send_and_predict(seq[i].kind, seq[i].rx);
  endtask

  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_and_predict(($urandom_range(15) == 0) ? KindRelease : KindByte,
                       8'($urandom_range(255)));
    end
  endtask

  task automatic run_mix(input int unsigned beats);
    int unsigned target;
    int          pick;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 75) send_frame(1'b0, -1);
      else if (pick < 90) send_frame(1'b1, -1);
      else send_noise($urandom_range(1, 6));
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      failures++;
    end
  endtask

  // output side: random stalls plus one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HoldOff;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("output beat with nothing expected: event %0d data %0h",
               m_axis_tuser_o, m_axis_tdata_o);
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("event_res", 16'(want.ev), 16'(m_axis_tuser_o));
        check_field("payload_byte", 16'(want.payload_byte), 16'(m_axis_tdata_o[7:0]));
        check_field("payload_index", 16'(want.payload_index), 16'(m_axis_tdata_o[14:8]));
        check_field("frame_command", 16'(want.frame_command), 16'(m_axis_tdata_o[22:15]));
        check_field("frame_length", 16'(want.frame_length), 16'(m_axis_tdata_o[30:23]));
        check_field("fault_code", 16'(want.fault_code), 16'(m_axis_tdata_o[33:31]));
        check_field("fault_count", 16'(want.fault_count), 16'(m_axis_tdata_o[41:34]));
      end
      beats_checked++;
      if (m_axis_tuser_o == EvGood) good_seen++;
      if (m_axis_tuser_o == EvFault) faults_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    fpr_result_t predicted;

    // registers at reset: all markers and codes zero
    add_row(KindByte, 8'h5A, 1'b1, EvFault, 8'h00, 8'h00, FaultStart, 8'd1);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h01, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'hFF, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b1, EvGood, 8'h00, 8'd1, FaultNone, 8'd1);
    add_row(KindByte, 8'h33, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindRelease, 8'hFF, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindRelease, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    // zero length frame with a bad checksum
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'hFE, 1'b1, EvFault, 8'h00, 8'h00, FaultCsum, 8'd2);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    // length of all ones
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'h00, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'hFF, 1'b0, EvPayload, 8'h00, 8'h00, FaultNone, 8'd0);
    add_row(KindByte, 8'hFF, 1'b1, EvFault, 8'h00, 8'h00, FaultTooLong, 8'd3);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed[i]) begin
      send_beat(directed[i].kind, directed[i].rx, predicted);
      if (directed[i].fixed) expected_results.push_back(directed[i].res);
      else if (predicted.valid) expected_results.push_back(predicted);
    end
    wait_quiet();

    // all ones, no idling on either side
    calm = 1'b1;
    program_regs(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    run_mix(PhaseBeats);
    wait_quiet();
    calm = 1'b0;

    // mixed extremes with a long output hold-off on a long frame
    program_regs(16'h0000, 16'hFFFF, 8'h00, 8'hFF);
    hold_req = 1'b1;
    send_frame(1'b0, 64);
    run_mix(PhaseBeats);
    wait_quiet();

    // random markers, heavy noise drives the fault count into saturation
    program_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    send_noise(NoiseBeats);
    run_mix(PhaseBeats);
    wait_quiet();

    program_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_mix(PhaseBeats);
    wait_quiet();

    program_regs(16'h8001, 16'h7FFE, 8'h80, 8'h01);
    run_mix(PhaseBeats);
    wait_quiet();

    if (expected_results.size() != 0) begin
      $error("%0d expected output beats never arrived", expected_results.size());
      failures += expected_results.size();
    end
    $display("sent %0d input beats over six register settings, checked %0d output beats",
             beats_sent, beats_checked);
    $display("good frames %0d, faults %0d, final fault count %0d, mismatches %0d",
             good_seen, faults_seen, tally, failures);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/fpr_pkg.sv
sv/fpr_parser.sv
sv/fpr_outbuf.sv
sv/framed_packet_receiver_top.sv
sv/fpr_checker.sv
tb/framed_packet_receiver_top_tb.sv
